// ===== rtl/core/rope_pkg.sv =====
`timescale 1ns / 1ps
package rope_pkg;

	// fixed build constants
	localparam int HALF_DIM_MAX  = 64;
	localparam int POS_BITS      = 16;
	localparam int DATA_BITS_DEF = 16;

	// config port
	localparam int IDX_W = 3;
	localparam int CFG_W = 21;

	typedef enum logic [IDX_W-1:0] {
		REG_MODE       = 3'd0,
		REG_LOG2_THETA = 3'd1,
		REG_LOG2_SCALE = 3'd2,
		REG_STEP_COUNT = 3'd3,
		REG_RAMP_LOW   = 3'd4,
		REG_RAMP_HIGH  = 3'd5,
		REG_HALF_DIM   = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_BASE   = 2'd0,
		MODE_INTERP = 2'd1,
		MODE_STEP   = 2'd2,
		MODE_RAMP   = 2'd3
	} freq_mode_t;

	// field and internal widths
	localparam int IW   = 6;   // pair index
	localparam int PW   = 16;  // position field
	localparam int H_W  = 7;   // half size
	localparam int E_W  = 22;  // exponent, Q.16
	localparam int M_W  = 17;  // blend mask, Q16 incl. one
	localparam int VP_W = 28;  // exponent times log2 theta, Q.16
	localparam int V_W  = 29;  // -log2 f, Q.16
	localparam int F_W  = 31;  // f, Q1.30 (at most one)
	localparam int TS_W = 47;  // turns per position, Q.48
	localparam int CW   = 33;  // CORDIC datapath
	localparam int CORDIC_ITERS = 24;

	localparam int H_CLAMP = (HALF_DIM_MAX > 127) ? 127 : HALF_DIM_MAX;
	localparam logic [PW-1:0] POS_MASK =
		(POS_BITS >= PW) ? {PW{1'b1}} : PW'((64'd1 << POS_BITS) - 64'd1);

	localparam logic [31:0] TURN_K          = 32'd2734261102;
	localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
	localparam logic [31:0] CORDIC_GAIN_INV = 32'd652032874;

	localparam logic [31:0] ATAN_Q30 [CORDIC_ITERS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	// floor square root, elaboration use only
	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = x_in;
		r = '0;
		for (int k = 31; k >= 0; k--) begin
			b = 64'd1 << (2 * k);
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	// 2^-(2^(j-16)) in Q30 via a chain of square roots from one half
	function automatic logic [29:0] exp2_coef(input int j);
		logic [63:0] t;
		t = 64'd1 << 29;
		for (int jj = 15; jj >= j; jj--) begin
			t = isqrt64(t << 30);
		end
		return t[29:0];
	endfunction

endpackage

// ===== rtl/core/rope_ifs.sv =====
`timescale 1ns / 1ps
interface rope_in_if #(parameter int DATA_BITS = rope_pkg::DATA_BITS_DEF);
	logic                        valid;
	logic                        ready;
	logic signed [DATA_BITS-1:0] x_low;
	logic signed [DATA_BITS-1:0] x_high;
	logic [rope_pkg::IW-1:0]     dim_index;
	logic [rope_pkg::PW-1:0]     position;

	modport source (output valid, x_low, x_high, dim_index, position, input ready);
	modport sink (input valid, x_low, x_high, dim_index, position, output ready);
endinterface

interface rope_out_if #(parameter int DATA_BITS = rope_pkg::DATA_BITS_DEF);
	logic                        valid;
	logic                        ready;
	logic signed [DATA_BITS-1:0] y_low;
	logic signed [DATA_BITS-1:0] y_high;
	logic                        saturated;

	modport source (output valid, y_low, y_high, saturated, input ready);
	modport sink (input valid, y_low, y_high, saturated, output ready);
endinterface

// ===== rtl/core/rope_div.sv =====
`timescale 1ns / 1ps
module rope_div #(
	parameter int LANES = 1,
	parameter int DEN_W = 8,
	parameter int QUO_W = 8,
	parameter int TAG_W = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_vld,
	input  logic [LANES-1:0][DEN_W-1:0]      den,
	input  logic [LANES-1:0][DEN_W-1:0]      rem_in,
	input  logic [LANES-1:0][QUO_W-1:0]      num_lo,
	input  logic [TAG_W-1:0]                 tag_in,
	output logic                             out_vld,
	output logic [LANES-1:0][QUO_W-1:0]      quo,
	output logic [TAG_W-1:0]                 tag_out
);
	// restoring divider, one quotient bit per stage; remainder in must be below den
	logic [LANES-1:0][DEN_W-1:0] rem_s [QUO_W+1];
	logic [LANES-1:0][DEN_W-1:0] den_s [QUO_W+1];
	logic [LANES-1:0][QUO_W-1:0] nq_s  [QUO_W+1];
	logic [TAG_W-1:0]            tag_s [QUO_W+1];
	logic                        vld_s [QUO_W+1];

	assign rem_s[0] = rem_in;
	assign den_s[0] = den;
	assign nq_s[0]  = num_lo;
	assign tag_s[0] = tag_in;
	assign vld_s[0] = in_vld;

	for (genvar k = 0; k < QUO_W; k++) begin : g_st
		logic [LANES-1:0][DEN_W-1:0] rem_nx;
		logic [LANES-1:0][QUO_W-1:0] nq_nx;

		always_comb begin
			logic [DEN_W:0] trial;
			logic [DEN_W:0] diff;
			for (int l = 0; l < LANES; l++) begin
				trial = {rem_s[k][l], nq_s[k][l][QUO_W-1]};
				diff  = trial - {1'b0, den_s[k][l]};
				if (trial >= {1'b0, den_s[k][l]}) begin
					rem_nx[l] = diff[DEN_W-1:0];
					nq_nx[l]  = {nq_s[k][l][QUO_W-2:0], 1'b1};
				end else begin
					rem_nx[l] = trial[DEN_W-1:0];
					nq_nx[l]  = {nq_s[k][l][QUO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= rem_nx;
				nq_s[k+1]  <= nq_nx;
				den_s[k+1] <= den_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	assign quo     = nq_s[QUO_W];
	assign tag_out = tag_s[QUO_W];
	assign out_vld = vld_s[QUO_W];

endmodule

// ===== rtl/core/rope_exp2.sv =====
`timescale 1ns / 1ps
module rope_exp2 #(
	parameter int TAG_W = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [rope_pkg::V_W-1:0]  v,
	input  logic [TAG_W-1:0]          tag_in,
	output logic                      out_vld,
	output logic [rope_pkg::F_W-1:0]  f,
	output logic [TAG_W-1:0]          tag_out
);
	import rope_pkg::*;

	localparam int NS = 16;

	// one fraction bit per stage, high to low, then the integer shift
	logic [F_W-1:0]   r_s   [NS+1];
	logic [V_W-1:0]   v_s   [NS+1];
	logic [TAG_W-1:0] tag_s [NS+1];
	logic             vld_s [NS+1];
	logic [V_W-17:0]  n_int;

	assign r_s[0]   = F_W'(64'd1 << 30);
	assign v_s[0]   = v;
	assign tag_s[0] = tag_in;
	assign vld_s[0] = in_vld;

	for (genvar k = 0; k < NS; k++) begin : g_st
		localparam logic [29:0] CJ = exp2_coef(NS - 1 - k);
		logic [60:0] prod;

		assign prod = 61'(r_s[k]) * 61'(CJ) + 61'(64'd1 << 29);

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1]   <= v_s[k][NS-1-k] ? F_W'(prod >> 30) : r_s[k];
				v_s[k+1]   <= v_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	assign n_int = v_s[NS][V_W-1:16];

	always_ff @(posedge clk) begin
		if (en) begin
			f       <= (n_int >= (V_W-16)'(31)) ? '0 : (r_s[NS] >> n_int[4:0]);
			tag_out <= tag_s[NS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s[NS];
		end
	end

endmodule

// ===== rtl/core/rope_cordic.sv =====
`timescale 1ns / 1ps
module rope_cordic #(
	parameter int TAG_W = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_vld,
	input  logic signed [rope_pkg::CW-1:0]  ang,
	input  logic [TAG_W-1:0]                tag_in,
	output logic                            out_vld,
	output logic signed [rope_pkg::CW-1:0]  cos_o,
	output logic signed [rope_pkg::CW-1:0]  sin_o,
	output logic [TAG_W-1:0]                tag_out
);
	import rope_pkg::*;

	localparam int N = CORDIC_ITERS;

	logic signed [CW-1:0] x_s   [N+1];
	logic signed [CW-1:0] y_s   [N+1];
	logic signed [CW-1:0] z_s   [N+1];
	logic [TAG_W-1:0]     tag_s [N+1];
	logic                 vld_s [N+1];

	assign x_s[0]   = CW'(CORDIC_GAIN_INV);
	assign y_s[0]   = '0;
	assign z_s[0]   = ang;
	assign tag_s[0] = tag_in;
	assign vld_s[0] = in_vld;

	for (genvar k = 0; k < N; k++) begin : g_it
		localparam logic signed [CW-1:0] ATN = CW'(ATAN_Q30[k]);
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;

		assign dx = y_s[k] >>> k;
		assign dy = x_s[k] >>> k;

		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[k] >= 0) begin
					x_s[k+1] <= x_s[k] - dx;
					y_s[k+1] <= y_s[k] + dy;
					z_s[k+1] <= z_s[k] - ATN;
				end else begin
					x_s[k+1] <= x_s[k] + dx;
					y_s[k+1] <= y_s[k] - dy;
					z_s[k+1] <= z_s[k] + ATN;
				end
				tag_s[k+1] <= tag_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	assign cos_o   = x_s[N];
	assign sin_o   = y_s[N];
	assign tag_out = tag_s[N];
	assign out_vld = vld_s[N];

endmodule

// ===== rtl/core/rope_rot_lane.sv =====
`timescale 1ns / 1ps
module rope_rot_lane #(
	parameter int DATA_BITS = rope_pkg::DATA_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic signed [DATA_BITS-1:0]    a,
	input  logic signed [DATA_BITS-1:0]    b,
	input  logic signed [rope_pkg::CW:0]   c,
	input  logic signed [rope_pkg::CW:0]   s,
	output logic                           out_vld,
	output logic signed [DATA_BITS-1:0]    y,
	output logic                           sat
);
	import rope_pkg::*;

	// y = round(a*c + b*s) in Q30, clipped to the data range
	localparam int MP_W = DATA_BITS + CW + 1;
	localparam int SM_W = MP_W + 1;
	localparam longint YMAX_L = (longint'(1) << (DATA_BITS - 1)) - 1;
	localparam logic signed [SM_W-1:0] YMAX = SM_W'(YMAX_L);
	localparam logic signed [SM_W-1:0] YMIN = -SM_W'(YMAX_L) - SM_W'(1);

	logic signed [MP_W-1:0] pa_s1;
	logic signed [MP_W-1:0] pb_s1;
	logic                   vld_s1;
	logic signed [SM_W-1:0] sum;
	logic signed [SM_W-1:0] yr;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1 <= MP_W'(a) * MP_W'(c);
			pb_s1 <= MP_W'(b) * MP_W'(s);
		end
	end

	assign sum = SM_W'(pa_s1) + SM_W'(pb_s1) + SM_W'(64'd1 << 29);
	assign yr  = sum >>> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			if (yr > YMAX) begin
				y   <= DATA_BITS'(YMAX);
				sat <= 1'b1;
			end else if (yr < YMIN) begin
				y   <= DATA_BITS'(YMIN);
				sat <= 1'b1;
			end else begin
				y   <= DATA_BITS'(yr);
				sat <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

endmodule

// ===== rtl/core/rotary_embedding_scaled_freq.sv =====
`timescale 1ns / 1ps
// Rotary position embedding with selectable frequency scaling. One rotary pair
// (x_low, x_high, pair index, position) goes in per item and one rotated,
// saturated pair comes out per item, in order. Fully pipelined: a new item is
// taken every cycle unless the output stalls. The stages run in order: input
// reg, exponent and mask dividers, stepwise re-quantise divider, scale multiply,
// exp2 lanes, blend/turns/phase/angle, CORDIC, quadrant, rotate. The two long
// dividers make up the largest part of the pipe, one quotient bit per stage. The
// whole pipe halts while a result waits at the output and ready is low. No
// clearing after reset. Config may only be written while the pipe is empty.
module rotary_embedding_scaled_freq #(
	parameter int DATA_BITS = rope_pkg::DATA_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rope_pkg::IDX_W-1:0]  cfg_index,
	input  logic [rope_pkg::CFG_W-1:0]  cfg_data,
	rope_in_if.sink                     in_ch,
	rope_out_if.source                  out_ch
);
	import rope_pkg::*;

	localparam int DB2 = 2 * DATA_BITS;
	localparam int T1  = DB2 + PW + 2;
	localparam int T2  = DB2 + PW + E_W + M_W;
	localparam int TE  = DB2 + PW;
	localparam int TC  = DB2 + 2;

	// ---- config registers ----
	freq_mode_t   mode_q;
	logic [20:0]  log2_theta_q;
	logic [19:0]  log2_scale_q;
	logic [15:0]  step_count_q;
	logic [5:0]   ramp_low_q;
	logic [5:0]   ramp_high_q;
	logic [6:0]   half_dim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_BASE;
			log2_theta_q <= 21'd870824;
			log2_scale_q <= '0;
			step_count_q <= 16'd1;
			ramp_low_q   <= '0;
			ramp_high_q  <= 6'd63;
			half_dim_q   <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODE:       mode_q       <= freq_mode_t'(cfg_data[1:0]);
				REG_LOG2_THETA: log2_theta_q <= cfg_data[20:0];
				REG_LOG2_SCALE: log2_scale_q <= cfg_data[19:0];
				REG_STEP_COUNT: step_count_q <= cfg_data[15:0];
				REG_RAMP_LOW:   ramp_low_q   <= cfg_data[5:0];
				REG_RAMP_HIGH:  ramp_high_q  <= cfg_data[5:0];
				REG_HALF_DIM:   half_dim_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// half size clamped to [1, max], zero steps act as one
	logic [H_W-1:0] h_eff;
	logic [15:0]    steps;

	always_comb begin
		if (half_dim_q == '0) begin
			h_eff = H_W'(1);
		end else if (half_dim_q > H_W'(H_CLAMP)) begin
			h_eff = H_W'(H_CLAMP);
		end else begin
			h_eff = half_dim_q;
		end
	end

	assign steps = (step_count_q == '0) ? 16'd1 : step_count_q;

	// ---- flow control: whole pipe moves unless the output is stuck ----
	logic en;
	logic out_vld;

	assign en          = !out_vld || out_ch.ready;
	assign in_ch.ready = en;

	// ---- blend mask operands, sign folded so the denominator is not negative ----
	logic signed [7:0] n0_c, d0_c, mnum_c, mden_c;
	logic              mone_c, mzero_c;

	always_comb begin
		n0_c = signed'({2'b00, in_ch.dim_index}) - signed'({2'b00, ramp_low_q});
		d0_c = signed'({2'b00, ramp_high_q}) - signed'({2'b00, ramp_low_q});
		if (d0_c < 8'sd0) begin
			mnum_c = -n0_c;
			mden_c = -d0_c;
		end else begin
			mnum_c = n0_c;
			mden_c = d0_c;
		end
		mone_c  = (d0_c == 8'sd0) || ((mnum_c > 8'sd0) && (mnum_c >= mden_c));
		mzero_c = (d0_c != 8'sd0) && (mnum_c <= 8'sd0);
	end

	// ---- s1: input register ----
	logic                        vld_s1;
	logic signed [DATA_BITS-1:0] xl_s1, xh_s1;
	logic [PW-1:0]               pos_s1;
	logic [IW-1:0]               i_s1;
	logic [E_W-1:0]              is_s1;
	logic [5:0]                  mnum_s1, mden_s1;
	logic                        mone_s1, mzero_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			xl_s1    <= in_ch.x_low;
			xh_s1    <= in_ch.x_high;
			pos_s1   <= in_ch.position & POS_MASK;
			i_s1     <= in_ch.dim_index;
			is_s1    <= E_W'(in_ch.dim_index) * E_W'(steps);
			mnum_s1  <= mnum_c[5:0];
			mden_s1  <= mden_c[5:0];
			mone_s1  <= mone_c;
			mzero_s1 <= mzero_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_ch.valid;
		end
	end

	// ---- divider lanes: exponent i/h, stepwise index i*S/h, mask ----
	logic [2:0][H_W-1:0] d1_den, d1_rem;
	logic [2:0][E_W-1:0] d1_num, d1_quo;
	logic [T1-1:0]       d1_tag_in, d1_tag;
	logic                d1_vld;

	assign d1_den    = {{1'b0, mden_s1}, h_eff, h_eff};
	assign d1_rem    = '0;
	assign d1_num    = {{mnum_s1, 16'b0}, is_s1, {i_s1, 16'b0}};
	assign d1_tag_in = {xl_s1, xh_s1, pos_s1, mone_s1, mzero_s1};

	rope_div #(
		.LANES (3),
		.DEN_W (H_W),
		.QUO_W (E_W),
		.TAG_W (T1)
	) u_div_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s1),
		.den     (d1_den),
		.rem_in  (d1_rem),
		.num_lo  (d1_num),
		.tag_in  (d1_tag_in),
		.out_vld (d1_vld),
		.quo     (d1_quo),
		.tag_out (d1_tag)
	);

	logic [DATA_BITS-1:0] xl_d1, xh_d1;
	logic [PW-1:0]        pos_d1;
	logic                 mone_d1, mzero_d1;
	logic [M_W-1:0]       m16_d1;
	logic [E_W-1:0]       qs_d1;

	assign {xl_d1, xh_d1, pos_d1, mone_d1, mzero_d1} = d1_tag;
	assign qs_d1  = d1_quo[1];
	assign m16_d1 = mone_d1 ? M_W'(32'h10000) : (mzero_d1 ? '0 : d1_quo[2][M_W-1:0]);

	// ---- stepwise re-quantise: (qs << 16) / S, quotient known below 2^22 ----
	logic [0:0][15:0]    d2_den, d2_rem;
	logic [0:0][E_W-1:0] d2_num, d2_quo;
	logic [T2-1:0]       d2_tag_in, d2_tag;
	logic                d2_vld;

	assign d2_den    = steps;
	assign d2_rem    = qs_d1[E_W-1:6];
	assign d2_num    = {qs_d1[5:0], 16'b0};
	assign d2_tag_in = {xl_d1, xh_d1, pos_d1, d1_quo[0], m16_d1};

	rope_div #(
		.LANES (1),
		.DEN_W (16),
		.QUO_W (E_W),
		.TAG_W (T2)
	) u_div_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (d1_vld),
		.den     (d2_den),
		.rem_in  (d2_rem),
		.num_lo  (d2_num),
		.tag_in  (d2_tag_in),
		.out_vld (d2_vld),
		.quo     (d2_quo),
		.tag_out (d2_tag)
	);

	logic [DATA_BITS-1:0] xl_d2, xh_d2;
	logic [PW-1:0]        pos_d2;
	logic [E_W-1:0]       e16_d2;
	logic [M_W-1:0]       m16_d2;

	assign {xl_d2, xh_d2, pos_d2, e16_d2, m16_d2} = d2_tag;

	// ---- s2: exponent times log2 theta (plus scale in base mode) ----
	logic [E_W-1:0]       ex_c, lmul_c;
	logic [2*E_W-1:0]     vprod_c;
	logic                 vld_s2;
	logic [VP_W-1:0]      vp_s2;
	logic [DATA_BITS-1:0] xl_s2, xh_s2;
	logic [PW-1:0]        pos_s2;
	logic [M_W-1:0]       m16_s2;

	assign ex_c    = (mode_q == MODE_STEP) ? d2_quo[0] : e16_d2;
	assign lmul_c  = (mode_q == MODE_BASE) ? (E_W'(log2_theta_q) + E_W'(log2_scale_q))
	                                       : E_W'(log2_theta_q);
	assign vprod_c = (2*E_W)'(ex_c) * (2*E_W)'(lmul_c);

	always_ff @(posedge clk) begin
		if (en) begin
			vp_s2  <= vprod_c[VP_W+15:16];
			xl_s2  <= xl_d2;
			xh_s2  <= xh_d2;
			pos_s2 <= pos_d2;
			m16_s2 <= m16_d2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= d2_vld;
		end
	end

	// ---- exp2 lanes: lane 0 the used frequency (the base one in ramp mode), lane 1 the scaled one ----
	logic [V_W-1:0]  vpls_c, v0_c;
	logic [F_W-1:0]  f0_e, f1_e;
	logic [TE-1:0]   e0_tag;
	logic [M_W-1:0]  m16_e;
	logic            e0_vld;

	assign vpls_c = V_W'(vp_s2) + V_W'(log2_scale_q);
	assign v0_c   = ((mode_q == MODE_BASE) || (mode_q == MODE_RAMP)) ? V_W'(vp_s2) : vpls_c;

	rope_exp2 #(.TAG_W (TE)) u_exp_0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.v       (v0_c),
		.tag_in  ({xl_s2, xh_s2, pos_s2}),
		.out_vld (e0_vld),
		.f       (f0_e),
		.tag_out (e0_tag)
	);

	rope_exp2 #(.TAG_W (M_W)) u_exp_1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.v       (vpls_c),
		.tag_in  (m16_s2),
		.out_vld (),
		.f       (f1_e),
		.tag_out (m16_e)
	);

	// ---- merge: blend, turns, phase, angle ----
	logic                 vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic [F_W+M_W-1:0]   bl_s3;
	logic [F_W-1:0]       f0_s3, f1_s3, f_s4;
	logic [TS_W-1:0]      ts_s5;
	logic [39:0]          plo_s6;
	logic [38:0]          phi_s6;
	logic [31:0]          t32_s7;
	logic [1:0]           q_s8, q_s9;
	logic                 neg_s8, neg_s9;
	logic [29:0]          mag_s8;
	logic [30:0]          angm_s9;
	logic [TE-1:0]        tg_s3, tg_s4, tg_s5;
	logic [DB2-1:0]       xx_s6, xx_s7, xx_s8, xx_s9;
	logic [PW-1:0]        pos_s5;

	logic [F_W+M_W:0]     blr_c;
	logic [62:0]          tsp_c;
	logic [47:0]          phase_c;
	logic [31:0]          qsum_c, r32_c, mag_c;
	logic [60:0]          angp_c;

	assign pos_s5  = tg_s5[PW-1:0];
	assign blr_c   = (F_W+M_W+1)'(bl_s3) + (F_W+M_W+1)'(32768);
	assign tsp_c   = 63'(f_s4) * 63'(TURN_K);
	assign phase_c = (48'(phi_s6) << 24) + 48'(plo_s6);
	assign qsum_c  = t32_s7 + 32'h2000_0000;
	assign r32_c   = t32_s7 - {qsum_c[31:30], 30'b0};
	assign mag_c   = r32_c[31] ? (32'd0 - r32_c) : r32_c;
	assign angp_c  = 61'(mag_s8) * 61'(HALF_PI_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			// s3: mask times the gap between the two frequencies
			bl_s3  <= (F_W+M_W)'(m16_e) * (F_W+M_W)'(f0_e - f1_e);
			f0_s3  <= f0_e;
			f1_s3  <= f1_e;
			tg_s3  <= e0_tag;
			// s4: chosen frequency
			f_s4   <= (mode_q == MODE_RAMP) ? (f1_s3 + F_W'(blr_c >> 16)) : f0_s3;
			tg_s4  <= tg_s3;
			// s5: turns per position step
			ts_s5  <= tsp_c[TS_W+15:16];
			tg_s5  <= tg_s4;
			// s6: position times step, split in two partial products
			plo_s6 <= 40'(pos_s5) * 40'(ts_s5[23:0]);
			phi_s6 <= 39'(pos_s5) * 39'(ts_s5[TS_W-1:24]);
			xx_s6  <= tg_s5[TE-1:PW];
			// s7: phase mod one turn, top 32 bits
			t32_s7 <= phase_c[47:16];
			xx_s7  <= xx_s6;
			// s8: nearest quadrant and signed remainder
			q_s8   <= qsum_c[31:30];
			neg_s8 <= r32_c[31];
			mag_s8 <= mag_c[29:0];
			xx_s8  <= xx_s7;
			// s9: remainder to radians
			angm_s9 <= angp_c[60:30];
			neg_s9  <= neg_s8;
			q_s9    <= q_s8;
			xx_s9   <= xx_s8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s3 <= e0_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// ---- CORDIC ----
	logic signed [CW-1:0] ang_c, cx, cy;
	logic [TC-1:0]        c_tag;
	logic                 c_vld;

	assign ang_c = neg_s9 ? -CW'(angm_s9) : CW'(angm_s9);

	rope_cordic #(.TAG_W (TC)) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s9),
		.ang     (ang_c),
		.tag_in  ({xx_s9, q_s9}),
		.out_vld (c_vld),
		.cos_o   (cx),
		.sin_o   (cy),
		.tag_out (c_tag)
	);

	// ---- s10: rotate cos/sin by the quadrant ----
	logic                        vld_s10;
	logic signed [CW:0]          cs_s10, sn_s10;
	logic signed [DATA_BITS-1:0] xl_s10, xh_s10;
	logic signed [CW:0]          cs_c, sn_c;

	always_comb begin
		case (c_tag[1:0])
			2'd0: begin
				cs_c = (CW+1)'(cx);
				sn_c = (CW+1)'(cy);
			end
			2'd1: begin
				cs_c = -(CW+1)'(cy);
				sn_c = (CW+1)'(cx);
			end
			2'd2: begin
				cs_c = -(CW+1)'(cx);
				sn_c = -(CW+1)'(cy);
			end
			default: begin
				cs_c = (CW+1)'(cy);
				sn_c = -(CW+1)'(cx);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s10 <= cs_c;
			sn_s10 <= sn_c;
			xl_s10 <= c_tag[TC-1:DATA_BITS+2];
			xh_s10 <= c_tag[DATA_BITS+1:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= c_vld;
		end
	end

	// ---- rotation lanes; their last stage is the output register ----
	logic sat_lo, sat_hi;

	rope_rot_lane #(.DATA_BITS (DATA_BITS)) u_rot_lo (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s10),
		.a       (xl_s10),
		.b       (xh_s10),
		.c       (cs_s10),
		.s       (-sn_s10),
		.out_vld (out_vld),
		.y       (out_ch.y_low),
		.sat     (sat_lo)
	);

	rope_rot_lane #(.DATA_BITS (DATA_BITS)) u_rot_hi (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s10),
		.a       (xh_s10),
		.b       (xl_s10),
		.c       (cs_s10),
		.s       (sn_s10),
		.out_vld (),
		.y       (out_ch.y_high),
		.sat     (sat_hi)
	);

	assign out_ch.valid     = out_vld;
	assign out_ch.saturated = sat_lo | sat_hi;

endmodule

// ===== verif/rotary_embedding_scaled_freq_test.sv =====
`timescale 1ns / 1ps
module rotary_embedding_scaled_freq_test;
	import rope_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 150;   // well past the depth of the pipe

	typedef struct {
		logic signed [15:0] x_low;
		logic signed [15:0] x_high;
		logic [5:0]         dim;
		logic [15:0]        pos;
	} pair_t;

	typedef struct {
		logic signed [15:0] y_low;
		logic signed [15:0] y_high;
		logic               sat;
	} rotated_t;

	// one directed row; the typed-in answer is used where has_ans is set
	typedef struct {
		pair_t    p;
		bit       has_ans;
		rotated_t ans;
	} row_t;

	typedef struct {
		freq_mode_t  mode;
		logic [20:0] lt;
		logic [19:0] ls;
		logic [15:0] steps;
		logic [5:0]  lo;
		logic [5:0]  hi;
		logic [6:0]  hd;
	} freq_cfg_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	rope_in_if  in_ch ();
	rope_out_if out_ch ();

	rotary_embedding_scaled_freq u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch.sink),
		.out_ch    (out_ch.source)
	);

	always #5 clk = ~clk;

	// predictor's copy of the registers
	freq_cfg_t cur;
	rotated_t  pending_pairs[$];
	int        err_count = 0;
	int        cycles = 0;
	logic [63:0] root_coef[16];   // 2^-(2^(j-16)) in Q30
	longint    arctan[24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// frequency 2^-(v/65536) in Q30
	function automatic logic [63:0] neg_pow2(input logic [63:0] v);
		logic [63:0] r;
		r = 64'd1 << 30;
		for (int j = 15; j >= 0; j--)
			if (v[j]) r = (r * root_coef[j] + (64'd1 << 29)) >> 30;
		if ((v >> 16) >= 31) return 0;
		return r >> (v >> 16);
	endfunction

	function automatic longint clip16(input longint v, inout logic sat);
		if (v > 32767) begin
			sat = 1'b1;
			return 32767;
		end
		if (v < -32768) begin
			sat = 1'b1;
			return -32768;
		end
		return v;
	endfunction

	function automatic rotated_t rotate_pair(input pair_t p);
		logic [63:0] h, steps, i, e16, f, f0, f1, vb, a16, m16, tstep, phase, mag, ang_mag;
		logic [31:0] t32, quad, r32;
		longint num, den, rem, ang, x, y, z, dx, dy, cs, sn, pl, ph;
		logic sat;
		rotated_t res;
		h = cur.hd;
		if (h < 1) h = 1;
		if (h > HALF_DIM_MAX) h = HALF_DIM_MAX;
		steps = (cur.steps == 0) ? 64'd1 : 64'(cur.steps);
		i = p.dim;
		e16 = (i << 16) / h;
		case (cur.mode)
			MODE_BASE: f = neg_pow2((e16 * (64'(cur.lt) + 64'(cur.ls))) >> 16);
			MODE_INTERP: f = neg_pow2(((e16 * cur.lt) >> 16) + cur.ls);
			MODE_STEP: begin
				a16 = (((i * steps) / h) << 16) / steps;
				f = neg_pow2(((a16 * cur.lt) >> 16) + cur.ls);
			end
			default: begin
				vb = (e16 * cur.lt) >> 16;
				f0 = neg_pow2(vb);
				f1 = neg_pow2(vb + cur.ls);
				num = longint'(i) - longint'(cur.lo);
				den = longint'(cur.hi) - longint'(cur.lo);
				// equal bounds: full mask; reversed bounds: fold the signs
				if (den == 0) m16 = 65536;
				else begin
					if (den < 0) begin
						den = -den;
						num = -num;
					end
					if (num <= 0) m16 = 0;
					else if (num >= den) m16 = 65536;
					else m16 = (64'(num) << 16) / 64'(den);
				end
				f = f1 + ((m16 * (f0 - f1) + 64'd32768) >> 16);
			end
		endcase
		tstep = (f * 64'd2734261102) >> 16;
		phase = (64'(p.pos) * tstep) & ((64'd1 << 48) - 1);
		t32 = phase[47:16];
		quad = ((t32 + 32'h2000_0000) >> 30) & 32'd3;
		r32 = t32 - (quad << 30);
		rem = longint'(signed'(r32));
		mag = (rem < 0) ? 64'(-rem) : 64'(rem);
		ang_mag = (mag * 64'd1686629713) >> 30;
		ang = (rem < 0) ? -longint'(ang_mag) : longint'(ang_mag);
		x = 652032874;
		y = 0;
		z = ang;
		for (int k = 0; k < 24; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan[k];
			end else begin
				x += dx; y -= dy; z += arctan[k];
			end
		end
		case (quad)
			0: begin cs = x;  sn = y;  end
			1: begin cs = -y; sn = x;  end
			2: begin cs = -x; sn = -y; end
			default: begin cs = y; sn = -x; end
		endcase
		pl = longint'(p.x_low) * cs - longint'(p.x_high) * sn;
		ph = longint'(p.x_high) * cs + longint'(p.x_low) * sn;
		sat = 1'b0;
		res.y_low = 16'(clip16((pl + (64'sd1 <<< 29)) >>> 30, sat));
		res.y_high = 16'(clip16((ph + (64'sd1 <<< 29)) >>> 30, sat));
		res.sat = sat;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		err_count++;
	endtask

	// ---- result side: random stalls, in-order compare ----
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			// mostly no stall, some short stalls, the odd long one
			case ($urandom_range(0, 19))
				0, 1, 2: stall_left <= $urandom_range(1, 3);
				3: stall_left <= $urandom_range(15, 60);
				default: stall_left <= 0;
			endcase
		end
	end

	rotated_t want;
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_pairs.size() == 0)
				report_mismatch("rotated pair with no item outstanding");
			else begin
				want = pending_pairs.pop_front();
				if (out_ch.y_low !== want.y_low)
					report_mismatch($sformatf("y_low %0d, want %0d", out_ch.y_low, want.y_low));
				if (out_ch.y_high !== want.y_high)
					report_mismatch($sformatf("y_high %0d, want %0d", out_ch.y_high,
						want.y_high));
				if (out_ch.saturated !== want.sat)
					report_mismatch($sformatf("saturated %b, want %b", out_ch.saturated,
						want.sat));
			end
		end
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("rotary_embedding_scaled_freq_test NOT OK");
			$finish;
		end
	end

	// ---- item side ----
	task automatic send_pair(input pair_t p, input bit has_ans, input rotated_t ans);
		int gap;
		case ($urandom_range(0, 15))
			0, 1, 2: gap = $urandom_range(1, 3);
			3: gap = $urandom_range(10, 40);
			default: gap = 0;
		endcase
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.x_low <= p.x_low;
		in_ch.x_high <= p.x_high;
		in_ch.dim_index <= p.dim;
		in_ch.position <= p.pos;
		do @(posedge clk); while (!in_ch.ready);
		pending_pairs.push_back(has_ans ? ans : rotate_pair(p));
	endtask

	task automatic idle_wait();
		in_ch.valid <= 1'b0;
		while (pending_pairs.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
	endtask

	// all seven registers, mirrored into the predictor at the register widths
	task automatic load_cfg(input freq_cfg_t c);
		write_reg(REG_MODE, CFG_W'(c.mode));
		write_reg(REG_LOG2_THETA, CFG_W'(c.lt));
		write_reg(REG_LOG2_SCALE, CFG_W'(c.ls));
		write_reg(REG_STEP_COUNT, CFG_W'(c.steps));
		write_reg(REG_RAMP_LOW, CFG_W'(c.lo));
		write_reg(REG_RAMP_HIGH, CFG_W'(c.hi));
		write_reg(REG_HALF_DIM, CFG_W'(c.hd));
		cfg_we <= 1'b0;
		@(posedge clk);
		cur = c;
	endtask

	function automatic pair_t random_pair();
		pair_t p;
		p.dim = 6'($urandom_range(0, 63));
		case ($urandom_range(0, 3))
			0: p.pos = 16'($urandom_range(0, 255));
			1: p.pos = 16'hFFFF - 16'($urandom_range(0, 15));
			default: p.pos = 16'($urandom);
		endcase
		if ($urandom_range(0, 7) == 0) begin
			p.x_low = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			p.x_high = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		end else begin
			p.x_low = 16'($urandom);
			p.x_high = 16'($urandom);
		end
		return p;
	endfunction

	// directed rows, run with reset settings; a zero pair rotates to zero
	row_t directed[] = '{
		'{'{16'sd0, 16'sd0, 6'd0, 16'd0}, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
		'{'{16'sd0, 16'sd0, 6'd63, 16'hFFFF}, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
		'{'{16'sh7FFF, 16'sh7FFF, 6'd0, 16'd0}, 1'b0, '{0, 0, 0}},
		'{'{16'sh8000, 16'sh8000, 6'd0, 16'd0}, 1'b0, '{0, 0, 0}},
		'{'{16'sh7FFF, 16'sh8000, 6'd0, 16'd1}, 1'b0, '{0, 0, 0}},
		'{'{16'sh8000, 16'sh7FFF, 6'd0, 16'hFFFF}, 1'b0, '{0, 0, 0}},
		'{'{16'sh7FFF, 16'sh7FFF, 6'd0, 16'd1}, 1'b0, '{0, 0, 0}},   // one radian, y_high clips
		'{'{16'sh8000, 16'sh8000, 6'd0, 16'd2}, 1'b0, '{0, 0, 0}},
		'{'{16'sh7FFF, 16'sd0, 6'd63, 16'hFFFF}, 1'b0, '{0, 0, 0}},
		'{'{16'sd0, 16'sh7FFF, 6'd63, 16'd1}, 1'b0, '{0, 0, 0}},
		'{'{16'sd2048, 16'sd0, 6'd1, 16'd1000}, 1'b0, '{0, 0, 0}},
		'{'{16'sd2048, 16'sd2048, 6'd32, 16'd12345}, 1'b0, '{0, 0, 0}},
		'{'{-16'sd1, 16'sd1, 6'd5, 16'h5555}, 1'b0, '{0, 0, 0}},
		'{'{16'sh5555, 16'shAAAA, 6'd42, 16'hAAAA}, 1'b0, '{0, 0, 0}},
		'{'{16'sh7FFF, 16'sh7FFF, 6'd10, 16'hFFFF}, 1'b0, '{0, 0, 0}}
	};

	// settings walk: every mode, extremes of each register, the odd ones
	// (half size zero and above range, zero steps, equal and reversed ramp)
	freq_cfg_t phases[] = '{
		'{MODE_BASE,   21'd870824,  20'd0,      16'd1,     6'd0,  6'd63, 7'd64},
		'{MODE_BASE,   21'h1FFFFF,  20'd524288, 16'd1,     6'd0,  6'd63, 7'd1},
		'{MODE_INTERP, 21'd0,       20'd524288, 16'd1,     6'd0,  6'd63, 7'd64},
		'{MODE_INTERP, 21'd870824,  20'hFFFFF,  16'd1,     6'd63, 6'd0,  7'd0},
		'{MODE_STEP,   21'd870824,  20'd65536,  16'd0,     6'd0,  6'd63, 7'd64},
		'{MODE_STEP,   21'h1FFFFF,  20'd131072, 16'hFFFF,  6'd0,  6'd63, 7'd127},
		'{MODE_STEP,   21'd870824,  20'd0,      16'd4,     6'd0,  6'd63, 7'd32},
		'{MODE_RAMP,   21'd870824,  20'd196608, 16'd1,     6'd10, 6'd40, 7'd64},
		'{MODE_RAMP,   21'd870824,  20'd524288, 16'd1,     6'd20, 6'd20, 7'd64},
		'{MODE_RAMP,   21'h1FFFFF,  20'd524288, 16'd1,     6'd50, 6'd5,  7'd16}
	};

	freq_cfg_t rc;
	rotated_t none;

	initial begin
		for (int j = 15; j >= 0; j--)
			root_coef[j] = floor_sqrt(((j == 15) ? (64'd1 << 29) : root_coef[j + 1]) << 30);
		cur = phases[0];   // reset values
		none = '{0, 0, 0};
		in_ch.valid = 1'b0;
		in_ch.x_low = '0;
		in_ch.x_high = '0;
		in_ch.dim_index = '0;
		in_ch.position = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[n])
			send_pair(directed[n].p, directed[n].has_ans, directed[n].ans);

		for (int ph = 0; ph < phases.size() + 3; ph++) begin
			idle_wait();
			if (ph < phases.size()) rc = phases[ph];
			else begin
				rc.mode = freq_mode_t'($urandom_range(0, 3));
				rc.lt = 21'($urandom);
				rc.ls = 20'($urandom_range(0, 524288));
				rc.steps = 16'($urandom_range(1, 65535));
				rc.lo = 6'($urandom);
				rc.hi = 6'($urandom);
				rc.hd = 7'($urandom_range(1, 64));
			end
			load_cfg(rc);
			for (int n = 0; n < 45; n++) begin
				// once, hold off mid-phase until the pipe has drained
				if (ph == 3 && n == 20) idle_wait();
				send_pair(random_pair(), 1'b0, none);
			end
		end

		idle_wait();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("rotary_embedding_scaled_freq_test OK");
		else
			$display("rotary_embedding_scaled_freq_test NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/rope_pkg.sv
rtl/core/rope_ifs.sv
rtl/core/rope_div.sv
rtl/core/rope_exp2.sv
rtl/core/rope_cordic.sv
rtl/core/rope_rot_lane.sv
rtl/core/rotary_embedding_scaled_freq.sv
verif/rotary_embedding_scaled_freq_test.sv
